// ===== rtl/ksfs_pkg.sv =====
package ksfs_pkg;

  // Code store: one entry is always left free, so it holds QUEUE_DEPTH-1 codes
  localparam int unsigned QUEUE_DEPTH    = 256;
  localparam int unsigned PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned KEYS_PER_GROUP = 32;
  localparam int unsigned KEY_W          = $clog2(KEYS_PER_GROUP);
  localparam int unsigned CODE_W         = 8;
  localparam logic [1:0]  NMI_PORT       = 2'd3;

  // Item buffer between front and back
  localparam int unsigned CMD_SLOTS = 2;
  localparam int unsigned SLOT_W    = $clog2(CMD_SLOTS);
  localparam int unsigned COUNT_W   = $clog2(CMD_SLOTS + 1);

  typedef struct packed {
    logic        mode;
    logic [1:0]  port_index;
    logic [31:0] old_bits;
    logic [31:0] new_bits;
  } ksfs_item_t;

  typedef struct packed {
    logic kind;
    logic serial_bit;
    logic last_bit;
  } ksfs_result_t;

  typedef enum logic [1:0] {
    OP_KEYS,
    OP_NMI,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  port;
    logic [31:0] delta;
    logic [31:0] new_bits;
  } ksfs_cmd_t;

endpackage

// ===== rtl/ksfs_front.sv =====
module ksfs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  ksfs_pkg::ksfs_item_t item_i,
  output logic                 cmd_valid_o,
  output ksfs_pkg::ksfs_cmd_t  cmd_o,
  input  logic                 cmd_take_i
);
  import ksfs_pkg::*;

  ksfs_cmd_t            slot_q [CMD_SLOTS];
  logic [SLOT_W-1:0]    wr_q, rd_q;
  logic [COUNT_W-1:0]   count_q;
  ksfs_cmd_t            cmd_in;
  logic                 do_push, do_take;

  always_comb begin
    cmd_in.port     = item_i.port_index;
    cmd_in.delta    = item_i.old_bits ^ item_i.new_bits;
    cmd_in.new_bits = item_i.new_bits;
    if (item_i.mode) begin
      cmd_in.op = OP_TICK;
    end else if (item_i.port_index == NMI_PORT && cmd_in.delta[KEYS_PER_GROUP-1] &&
                 item_i.new_bits[KEYS_PER_GROUP-1]) begin
      cmd_in.op = OP_NMI;
    end else begin
      cmd_in.op = OP_KEYS;
    end
  end

  assign full        = (count_q == COUNT_W'(CMD_SLOTS));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_take     = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == SLOT_W'(CMD_SLOTS - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_take) begin
        rd_q <= (rd_q == SLOT_W'(CMD_SLOTS - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_take) begin
        count_q <= count_q + 1'b1;
      end else if (do_take && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ksfs_back.sv =====
module ksfs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  ksfs_pkg::ksfs_cmd_t    cmd_i,
  output logic                   cmd_take_o,
  output logic                   empty,
  input  logic                   pop,
  output ksfs_pkg::ksfs_result_t result_o
);
  import ksfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_SEND,
    ST_NMI
  } state_e;

  state_e             state_q;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [1:0]         port_q;
  logic [31:0]        delta_q, newv_q;
  logic [KEY_W-1:0]   key_q;
  logic [CODE_W-1:0]  shift_q;
  logic [2:0]         cnt_q;
  logic               out_valid_q;
  ksfs_result_t       out_q;

  logic [CODE_W-1:0]  code_mem_q [QUEUE_DEPTH];
  logic [CODE_W-1:0]  rdata_q;

  logic               q_full, q_empty, slot_free, out_load;
  logic               wr_en, rd_en;
  logic [CODE_W-1:0]  wdata;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_full    = (ptr_next(wr_ptr_q) == rd_ptr_q);
  assign q_empty   = (wr_ptr_q == rd_ptr_q);
  assign slot_free = !out_valid_q || pop;
  assign out_load  = slot_free && ((state_q == ST_SEND) || (state_q == ST_NMI));

  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign rd_en      = cmd_take_o && (cmd_i.op == OP_TICK) && !q_empty;
  assign wr_en      = (state_q == ST_SCAN) && delta_q[0] && !q_full;
  // code = ~{key number, released}
  assign wdata      = ~{port_q, key_q, ~newv_q[0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      code_mem_q[wr_ptr_q] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= code_mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      port_q      <= '0;
      delta_q     <= '0;
      newv_q      <= '0;
      key_q       <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a new result may replace the one transferred at this edge
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_NMI: state_q <= ST_NMI;
              OP_KEYS: begin
                port_q  <= cmd_i.port;
                delta_q <= cmd_i.delta;
                newv_q  <= cmd_i.new_bits;
                key_q   <= '0;
                state_q <= ST_SCAN;
              end
              OP_TICK: begin
                if (!q_empty) begin
                  rd_ptr_q <= ptr_next(rd_ptr_q);
                  state_q  <= ST_LOAD;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (wr_en) begin
            wr_ptr_q <= ptr_next(wr_ptr_q);
          end
          delta_q <= delta_q >> 1;
          newv_q  <= newv_q >> 1;
          key_q   <= key_q + 1'b1;
          // stop after the highest changed key
          if (delta_q[31:1] == '0) begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          shift_q <= rdata_q;
          cnt_q   <= '0;
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (slot_free) begin
            out_q.kind       <= 1'b0;
            out_q.serial_bit <= shift_q[0];
            out_q.last_bit   <= (cnt_q == 3'd7);
            shift_q          <= shift_q >> 1;
            cnt_q            <= cnt_q + 1'b1;
            if (cnt_q == 3'd7) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_NMI: begin
          if (slot_free) begin
            out_q.kind       <= 1'b1;
            out_q.serial_bit <= 1'b0;
            out_q.last_bit   <= 1'b1;
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== rtl/keyboard_scancode_fifo_serializer_core.sv =====
// Keyboard scancode encoder and serializer. Key-change items are buffered in a
// two-entry queue and then scanned one key per cycle: each changed key writes
// one 8-bit code into a 256-entry code store, and the scan ends after the highest
// changed key. When the store is full (255 codes) further codes are dropped.
// Pressing key 31 of group 3 yields a single NMI result instead. A tick item
// reads one code (a registered store read, then a load of the shifter) and then
// sends its 8 bits LSB first, one per cycle while the result side keeps up. A
// tick on an empty store produces nothing. The code store needs no clear after
// reset.
module keyboard_scancode_fifo_serializer_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  ksfs_pkg::ksfs_item_t   item_i,
  output logic                   empty,
  input  logic                   pop,
  output ksfs_pkg::ksfs_result_t result_o
);
  import ksfs_pkg::*;

  logic      cmd_valid, cmd_take;
  ksfs_cmd_t cmd;

  ksfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  ksfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |-> cmd_valid)
    else $error("back took a command that was not there");

  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_take |=> cmd_valid && $stable(cmd))
    else $error("buffered command changed before transfer");

  a_full_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("front full without a pending command");

  a_nmi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && result_o.kind |-> result_o.last_bit && !result_o.serial_bit)
    else $error("malformed nmi result");

endmodule
